// File: src/kick_drum_voice_synth_unit_assert.svh
// assertion macros for the kick drum voice checker
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef KICK_DRUM_VOICE_SYNTH_UNIT_ASSERT_SVH
`define KICK_DRUM_VOICE_SYNTH_UNIT_ASSERT_SVH
// consequent in the cycle after the antecedent
`define KDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// consequent in the same cycle as the antecedent
`define KDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

// File: src/kdv_pkg.sv
// shared types, constants and tables of the kick drum voice
// no dependencies
`default_nettype none
package kdv_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int TANH_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 24;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int VW     = SAMPLE_BITS + 3;
  localparam int DIV_STEPS = 26;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [24:0] AMP_FLOOR = 25'd16778;
  localparam logic [16:0] FADE_ONE  = 17'd65536;
  localparam logic [25:0] SIN_C1 = 26'd26353589;
  localparam logic [25:0] SIN_C3 = 26'd10837479;
  localparam logic [25:0] SIN_C5 = 26'd1337020;
  localparam logic [25:0] SIN_C7 = 26'd78547;
  localparam logic [PROD_W-1:0] TANH_C0 = PROD_W'(64'd135135 << 24);
  localparam logic signed [63:0] FULL_SCALE = 64'sd1 <<< (SAMPLE_BITS - 1);

  typedef enum logic [2:0] {
    CFG_BASE_INC  = 3'd0,
    CFG_PITCH_DEC = 3'd1,
    CFG_AMP_DEC   = 3'd2,
    CFG_DRIVE     = 3'd3,
    CFG_NORM      = 3'd4,
    CFG_VOLUME    = 3'd5,
    CFG_DECLICK   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] base_increment;
    logic [23:0] pitch_decay;
    logic [23:0] amp_decay;
    logic [14:0] drive_gain;
    logic [15:0] drive_norm;
    logic [15:0] volume;
    logic [15:0] declick_step;
  } cfg_t;

  typedef enum logic [4:0] {
    U_TRIG, U_INC, U_X2, U_S7, U_S5, U_S3, U_Y, U_AMP, U_HG, U_DRV,
    U_TX2, U_TX4, U_TX6, U_N2, U_N4, U_D2, U_D4, U_XN, U_DN,
    U_F1, U_F2, U_VOL, U_PE, U_AE
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_ISSUE, ST_WB, ST_DIV, ST_PASS
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic wb;
    logic div_step;
    logic pass;
    uop_t uop;
  } dp_cmd_t;

  typedef struct packed {
    logic tick;
    logic active;
    logic drive_on;
    logic tanh_big;
    logic fade_go;
    logic out_busy;
  } dp_stat_t;

  // 2^(n/12) in Q1.16
  function automatic logic [16:0] semi_ratio(input logic [3:0] r);
    logic [16:0] v;
    case (r)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd69433;
      4'd2:    v = 17'd73562;
      4'd3:    v = 17'd77936;
      4'd4:    v = 17'd82570;
      4'd5:    v = 17'd87480;
      4'd6:    v = 17'd92682;
      4'd7:    v = 17'd98193;
      4'd8:    v = 17'd104032;
      4'd9:    v = 17'd110218;
      4'd10:   v = 17'd116772;
      4'd11:   v = 17'd123715;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/kdv_if.sv
// input and result channel interfaces of the kick drum voice
// no dependencies
`default_nettype none
interface kdv_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [6:0]  semitone_offset;
  logic [15:0]        level_gain;
  logic signed [23:0] mix_in;
  modport source (output valid, kind, semitone_offset, level_gain, mix_in, input ready);
  modport sink   (input valid, kind, semitone_offset, level_gain, mix_in, output ready);
endinterface

interface kdv_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mix_out;
  logic               voice_on;
  modport source (output valid, mix_out, voice_on, input ready);
  modport sink   (input valid, mix_out, voice_on, output ready);
endinterface
`default_nettype wire

// File: src/kick_drum_voice_synth_unit.sv
// kick drum voice: top level joining configuration, sequencer and datapath
// depends on kdv_pkg, kdv_if, kdv_cfg_regs, kdv_ctrl, kdv_datapath
//
// One kick-drum voice that adds its sample into a running mix. A trigger
// transaction (kind 0) sets the start pitch, latches the level and restarts the
// voice; it gives no result. A tick transaction (kind 1) gives one result:
// mix_in plus the voice sample times volume, saturated; a tick while the voice
// is silent passes mix_in through. A sounding tick runs the phase, sine and
// envelope steps, the crossfade steps while a crossfade runs, and with drive on
// a tanh curve, whose rational and division are skipped when the drive input
// saturates it. All products go through a single shared 34x34 multiplier, and
// a radix-2 divider of 26 steps serves the tanh rational. One transaction is
// worked at a time; a finished result sits in the output register while the
// next transaction is taken, and a tick only stalls at its end if that result
// has not been collected. Configuration writes take effect on the next cycle.
`default_nettype none
module kick_drum_voice_synth_unit import kdv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  kdv_in_if.sink           in_chan,
  kdv_out_if.source        out_chan,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  kdv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: one transaction at a time
  kdv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // arithmetic, voice state and output register
  kdv_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_chan.kind),
    .in_semi      (in_chan.semitone_offset),
    .in_level     (in_chan.level_gain),
    .in_mix       (in_chan.mix_in),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_mix      (out_chan.mix_out),
    .out_voice_on (out_chan.voice_on)
  );

  assign in_chan.ready = in_ready;
endmodule
`default_nettype wire

// File: src/kdv_cfg_regs.sv
// configuration register file of the kick drum voice
// depends on kdv_pkg
`default_nettype none
module kdv_cfg_regs import kdv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_increment <= 32'd5368709;
      cfg_r.pitch_decay    <= 24'd16768477;
      cfg_r.amp_decay      <= 24'd16775627;
      cfg_r.drive_gain     <= 15'd9011;
      cfg_r.drive_norm     <= 16'd16791;
      cfg_r.volume         <= 16'd32768;
      cfg_r.declick_step   <= 16'd273;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE_INC:  cfg_r.base_increment <= cfg_data;
        CFG_PITCH_DEC: cfg_r.pitch_decay    <= cfg_data[23:0];
        CFG_AMP_DEC:   cfg_r.amp_decay      <= cfg_data[23:0];
        CFG_DRIVE:     cfg_r.drive_gain     <= cfg_data[14:0];
        CFG_NORM:      cfg_r.drive_norm     <= cfg_data[15:0];
        CFG_VOLUME:    cfg_r.volume         <= cfg_data[15:0];
        CFG_DECLICK:   cfg_r.declick_step   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule
`default_nettype wire

// File: src/kdv_ctrl.sv
// sequencer of the kick drum voice: steps the datapath through its micro-ops
// depends on kdv_pkg
`default_nettype none
module kdv_ctrl import kdv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  dp_stat_t  stat,
  output logic      in_ready,
  output dp_cmd_t   cmd
);
  state_t state_r, state_nxt;
  uop_t   uop_r, uop_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic   wb_go;

  function automatic uop_t follow(input uop_t u, input dp_stat_t s);
    uop_t n;
    case (u)
      U_INC:   n = U_X2;
      U_X2:    n = U_S7;
      U_S7:    n = U_S5;
      U_S5:    n = U_S3;
      U_S3:    n = U_Y;
      U_Y:     n = U_AMP;
      U_AMP:   n = U_HG;
      U_HG:    n = s.drive_on ? U_DRV : (s.fade_go ? U_F1 : U_VOL);
      U_DRV:   n = s.tanh_big ? U_DN : U_TX2;
      U_TX2:   n = U_TX4;
      U_TX4:   n = U_TX6;
      U_TX6:   n = U_N2;
      U_N2:    n = U_N4;
      U_N4:    n = U_D2;
      U_D2:    n = U_D4;
      U_D4:    n = U_XN;
      U_DN:    n = s.fade_go ? U_F1 : U_VOL;
      U_F1:    n = U_F2;
      U_F2:    n = U_VOL;
      U_VOL:   n = U_PE;
      U_PE:    n = U_AE;
      default: n = U_AE;
    endcase
    return n;
  endfunction

  // the last step of a tick waits for the result register
  assign wb_go = !(uop_r == U_AE && stat.out_busy);

  always_comb begin
    state_nxt = state_r;
    uop_nxt   = uop_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (!stat.tick) begin
          uop_nxt   = U_TRIG;
          state_nxt = ST_ISSUE;
        end else if (stat.active) begin
          uop_nxt   = U_INC;
          state_nxt = ST_ISSUE;
        end else begin
          state_nxt = ST_PASS;
        end
      end
      ST_ISSUE: state_nxt = ST_WB;
      ST_WB: begin
        if (wb_go) begin
          if (uop_r == U_TRIG || uop_r == U_AE) begin
            state_nxt = ST_IDLE;
          end else if (uop_r == U_XN) begin
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end else begin
            uop_nxt   = follow(uop_r, stat);
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          uop_nxt   = U_DN;
          state_nxt = ST_ISSUE;
        end
      end
      ST_PASS: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.issue    = (state_r == ST_ISSUE);
    cmd.wb       = (state_r == ST_WB) && wb_go;
    cmd.div_step = (state_r == ST_DIV);
    cmd.pass     = (state_r == ST_PASS) && !stat.out_busy;
    cmd.uop      = uop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      uop_r   <= U_TRIG;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      uop_r   <= uop_nxt;
      cnt_r   <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// File: src/kdv_datapath.sv
// datapath of the kick drum voice: shared multiplier, divider, voice state, result register
// depends on kdv_pkg
`default_nettype none
module kdv_datapath import kdv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  wire logic               in_kind,
  input  wire logic signed [6:0]  in_semi,
  input  wire logic [15:0]        in_level,
  input  wire logic signed [23:0] in_mix,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_mix,
  output logic                    out_voice_on
);
  localparam int SB = SAMPLE_BITS;
  localparam int STB = SINE_TABLE_BITS;
  localparam int TB = TANH_TABLE_BITS;
  localparam logic signed [VW-1:0] V_MAX = VW'(FULL_SCALE - 64'sd1);
  localparam logic signed [VW-1:0] V_MIN = VW'(-FULL_SCALE);
  localparam logic [STB-2:0] QUARTER = (STB-1)'(1 << (STB - 2));

  // latched item
  logic               kind_r;
  logic signed [6:0]  semi_r;
  logic [15:0]        level_r;
  logic signed [23:0] mix_r;

  // voice state
  logic               active_r, fade_on_r;
  logic [31:0]        phase_r, start_r;
  logic [24:0]        pe_r, ae_r;
  logic [15:0]        hit_r;
  logic signed [SB-1:0] fade_from_r, last_r;
  logic [16:0]        fade_pos_r;

  // working registers
  logic signed [PROD_W-1:0] p_r;
  logic [PROD_W-1:0]  acc_r;
  logic [24:0]        s_r;
  logic [25:0]        tx_r;
  logic [27:0]        x2_r;
  logic [31:0]        x4_r;
  logic [35:0]        x6_r;
  logic [30:0]        num_r;
  logic [32:0]        den_r, rem_r;
  logic [25:0]        dq_r;
  logic               uneg_r, big_r;
  logic signed [VW-1:0] v_r;
  logic signed [23:0] mix_res_r;

  logic               out_valid_r, out_voice_r;
  logic signed [23:0] out_mix_r;

  logic [MUL_W-1:0]   a_op, b_op;
  logic [PROD_W-1:0]  pu;

  function automatic logic signed [PROD_W-1:0] tshift(
    input logic signed [PROD_W-1:0] p, input int k);
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? $signed((PROD_W'(1) << k) - PROD_W'(1)) : '0;
    return (p + bias) >>> k;
  endfunction

  assign pu = p_r;

  // start pitch: octave and semitone from n + 72
  logic [7:0]  n72;
  logic [3:0]  oct_q, semi_rem;
  logic [15:0] q_prod;
  logic [7:0]  rem8;
  logic [63:0] trig_wide;
  always_comb begin
    n72      = 8'($signed({semi_r[6], semi_r}) + 8'sd72);
    q_prod   = 16'(n72) * 16'd171;
    oct_q    = 4'(q_prod >> 11);
    rem8     = n72 - 8'(oct_q) * 8'd12;
    semi_rem = rem8[3:0];
    trig_wide = ({15'd0, pu[48:0]} << oct_q) >> 22;
  end

  // sine table point from the phase
  logic [STB-1:0] s_idx;
  logic [STB-2:0] s_w;
  logic [24:0]    sine_x;
  logic           sine_neg;
  always_comb begin
    s_idx    = phase_r[31 -: STB];
    s_w      = {1'b0, s_idx[STB-3:0]};
    if (s_idx[STB-2]) s_w = QUARTER - s_w;
    sine_x   = 25'(s_w) << (26 - STB);
    sine_neg = s_idx[STB-1];
  end

  // sine magnitude to a signed sample
  logic [24:0]  y_c;
  logic [63:0]  mag64;
  logic signed [63:0] vy64;
  always_comb begin
    y_c = (pu >> 24) > PROD_W'(ONE_Q24) ? ONE_Q24 : 25'(pu >> 24);
    mag64 = (64'(y_c) << (SB - 1)) >> 24;
    if (mag64 > 64'(FULL_SCALE - 64'sd1)) mag64 = 64'(FULL_SCALE - 64'sd1);
    vy64 = sine_neg ? -$signed(mag64) : $signed(mag64);
  end

  // drive input and tanh table point
  logic signed [PROD_W-1:0] u_s;
  logic [PROD_W-1:0] u_m, t_idx;
  logic              u_big;
  always_comb begin
    u_s   = tshift(p_r, 12);
    u_m   = u_s[PROD_W-1] ? PROD_W'(-u_s) : PROD_W'(u_s);
    t_idx = u_m >> (SB + 1 - TB);
    u_big = (t_idx >> TB) != '0;
  end

  // tanh value, drive output
  logic [24:0]  t_sel;
  logic [63:0]  m64;
  logic signed [63:0] vd64;
  always_comb begin
    t_sel = (big_r || dq_r > 26'(ONE_Q24)) ? ONE_Q24 : dq_r[24:0];
    m64   = (64'(pu >> 14) << (SB - 1)) >> 24;
    vd64  = uneg_r ? -$signed(m64) : $signed(m64);
  end

  // restoring division step
  logic [33:0] r2;
  logic        ge;
  always_comb begin
    r2 = {rem_r, dq_r[25]};
    ge = r2 >= {1'b0, den_r};
  end

  // clamped voice sample
  logic signed [SB-1:0] vc;
  always_comb begin
    if (v_r > V_MAX)      vc = SB'(V_MAX);
    else if (v_r < V_MIN) vc = SB'(V_MIN);
    else                  vc = SB'(v_r);
  end

  // volume and mix
  logic signed [PROD_W-1:0] r_s;
  logic signed [26:0] mix_sum;
  logic signed [23:0] mix_sat;
  logic [17:0]        pos_sum;
  always_comb begin
    r_s     = tshift(p_r, SB - 9);
    mix_sum = 27'(mix_r) + 27'(r_s);
    if (mix_sum > 27'sd8388607)       mix_sat = 24'sd8388607;
    else if (mix_sum < -27'sd8388608) mix_sat = -24'sd8388608;
    else                              mix_sat = 24'(mix_sum);
    pos_sum = 18'(fade_pos_r) + 18'(cfg.declick_step);
  end

  // multiplier operands
  always_comb begin
    a_op = '0;
    b_op = '0;
    case (cmd.uop)
      U_TRIG: begin a_op = MUL_W'(cfg.base_increment); b_op = MUL_W'(semi_ratio(semi_rem)); end
      U_INC:  begin a_op = MUL_W'(start_r); b_op = MUL_W'(26'(ONE_Q24) + 26'(pe_r)); end
      U_X2:   begin a_op = MUL_W'(sine_x); b_op = MUL_W'(sine_x); end
      U_S7:   begin a_op = MUL_W'(SIN_C7); b_op = MUL_W'(x2_r); end
      U_S5:   begin a_op = MUL_W'(s_r); b_op = MUL_W'(x2_r); end
      U_S3:   begin a_op = MUL_W'(s_r); b_op = MUL_W'(x2_r); end
      U_Y:    begin a_op = MUL_W'(s_r); b_op = MUL_W'(sine_x); end
      U_AMP:  begin a_op = MUL_W'(v_r); b_op = MUL_W'(ae_r); end
      U_HG:   begin a_op = MUL_W'(v_r); b_op = MUL_W'(hit_r); end
      U_DRV:  begin a_op = MUL_W'(v_r); b_op = MUL_W'(cfg.drive_gain); end
      U_TX2:  begin a_op = MUL_W'(tx_r); b_op = MUL_W'(tx_r); end
      U_TX4:  begin a_op = MUL_W'(x2_r); b_op = MUL_W'(x2_r); end
      U_TX6:  begin a_op = MUL_W'(x4_r); b_op = MUL_W'(x2_r); end
      U_N2:   begin a_op = MUL_W'(x2_r); b_op = MUL_W'(17325); end
      U_N4:   begin a_op = MUL_W'(x4_r); b_op = MUL_W'(378); end
      U_D2:   begin a_op = MUL_W'(x2_r); b_op = MUL_W'(62370); end
      U_D4:   begin a_op = MUL_W'(x4_r); b_op = MUL_W'(3150); end
      U_XN:   begin a_op = MUL_W'(tx_r); b_op = MUL_W'(num_r); end
      U_DN:   begin a_op = MUL_W'(t_sel); b_op = MUL_W'(cfg.drive_norm); end
      U_F1:   begin a_op = MUL_W'(fade_from_r); b_op = MUL_W'(FADE_ONE - fade_pos_r); end
      U_F2:   begin a_op = MUL_W'(vc); b_op = MUL_W'(fade_pos_r); end
      U_VOL:  begin a_op = MUL_W'(vc); b_op = MUL_W'(cfg.volume); end
      U_PE:   begin a_op = MUL_W'(pe_r); b_op = MUL_W'(cfg.pitch_decay); end
      U_AE:   begin a_op = MUL_W'(ae_r); b_op = MUL_W'(cfg.amp_decay); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) p_r <= $signed(a_op) * $signed(b_op);
    if (cmd.load) begin
      kind_r  <= in_kind;
      semi_r  <= in_semi;
      level_r <= in_level;
      mix_r   <= in_mix;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? 33'(r2 - {1'b0, den_r}) : r2[32:0];
      dq_r  <= {dq_r[24:0], ge};
    end
    if (cmd.wb) begin
      case (cmd.uop)
        U_X2:  x2_r <= 28'(pu >> 24);
        U_S7:  s_r <= 25'(SIN_C5 - 26'(pu >> 24));
        U_S5:  s_r <= 25'(SIN_C3 - 26'(pu >> 24));
        U_S3:  s_r <= 25'(SIN_C1 - 26'(pu >> 24));
        U_Y:   v_r <= VW'(vy64);
        U_AMP: v_r <= VW'(tshift(p_r, 24));
        U_HG:  v_r <= VW'(tshift(p_r, 15));
        U_DRV: begin
          uneg_r <= u_s[PROD_W-1];
          big_r  <= u_big;
          tx_r   <= 26'(t_idx[TB-1:0]) << (26 - TB);
        end
        U_TX2: x2_r <= 28'(pu >> 24);
        U_TX4: x4_r <= 32'(pu >> 24);
        U_TX6: x6_r <= 36'(pu >> 24);
        U_N2:  acc_r <= TANH_C0 + pu;
        U_N4:  num_r <= 31'((acc_r + pu + PROD_W'(x6_r)) >> 12);
        U_D2:  acc_r <= TANH_C0 + pu;
        U_D4:  den_r <= 33'((acc_r + pu + (PROD_W'(x6_r) << 5) - (PROD_W'(x6_r) << 2)) >> 12);
        U_XN: begin
          rem_r <= 33'(pu[56:26]);
          dq_r  <= pu[25:0];
        end
        U_DN:  v_r <= VW'(vd64);
        U_F1:  acc_r <= pu;
        U_F2:  v_r <= VW'(tshift($signed(acc_r) + p_r, 16));
        U_VOL: mix_res_r <= mix_sat;
        default: ;
      endcase
    end
  end

  // voice state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      fade_on_r   <= 1'b0;
      phase_r     <= '0;
      pe_r        <= '0;
      ae_r        <= '0;
      start_r     <= '0;
      hit_r       <= '0;
      fade_from_r <= '0;
      fade_pos_r  <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      out_voice_r <= 1'b0;
      out_mix_r   <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.pass) begin
        out_valid_r <= 1'b1;
        out_mix_r   <= mix_r;
        out_voice_r <= 1'b0;
      end
      if (cmd.wb) begin
        case (cmd.uop)
          U_TRIG: begin
            start_r     <= (trig_wide[63:32] != '0) ? '1 : trig_wide[31:0];
            fade_on_r   <= active_r;
            if (active_r) fade_from_r <= last_r;
            fade_pos_r  <= '0;
            active_r    <= 1'b1;
            phase_r     <= '0;
            pe_r        <= ONE_Q24;
            ae_r        <= ONE_Q24;
            hit_r       <= level_r;
          end
          U_INC: begin
            phase_r <= phase_r + pu[56:25];
            // a finished crossfade ends on the tick after it reaches full
            if (fade_on_r && fade_pos_r >= FADE_ONE) fade_on_r <= 1'b0;
          end
          U_F2:  fade_pos_r <= (pos_sum > 18'(FADE_ONE)) ? FADE_ONE : pos_sum[16:0];
          U_VOL: last_r <= vc;
          U_PE:  pe_r <= 25'(pu >> 24);
          U_AE: begin
            ae_r <= 25'(pu >> 24);
            if (ae_r < AMP_FLOOR) active_r <= 1'b0;
            out_valid_r <= 1'b1;
            out_mix_r   <= mix_res_r;
            out_voice_r <= !(ae_r < AMP_FLOOR);
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    stat.tick     = kind_r;
    stat.active   = active_r;
    stat.drive_on = cfg.drive_gain != '0;
    stat.tanh_big = u_big;
    stat.fade_go  = fade_on_r && (fade_pos_r < FADE_ONE);
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_mix      = out_mix_r;
  assign out_voice_on = out_voice_r;
endmodule
`default_nettype wire

// File: src/kdv_checker.sv
// port-level checks of the kick drum voice, bound to the top level
// depends on kick_drum_voice_synth_unit_assert.svh
`default_nettype none
`include "kick_drum_voice_synth_unit_assert.svh"
module kdv_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_kind,
  input wire logic out_valid,
  input wire logic out_ready
);
  `KDV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `KDV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "took a second transaction")
  `KDV_ASSERT_NEXT(a_trig_silent, in_valid && in_ready && !in_kind, !$rose(out_valid), "trigger made a result")
  `KDV_ASSERT_NOW(a_result_from_work, $rose(out_valid), !$past(in_ready), "result with no work")
endmodule

bind kick_drum_voice_synth_unit kdv_checker u_kdv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_kind   (in_chan.kind),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready)
);
`default_nettype wire

// File: tb/sv/kdv_voice_checker.sv
// transaction checker of the kick drum voice: tracks the register file, predicts
// every tick result and compares it with what leaves the result channel
// depends on kdv_pkg and the channel interfaces of kdv_if
`default_nettype none
module kdv_voice_checker import kdv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  kdv_in_if                in_mon,
  kdv_out_if               out_mon,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               sample_count,
  output int               hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned Q24_ONE = 64'd16777216;
  localparam longint unsigned LEVEL_FLOOR = 64'd16778;
  localparam longint unsigned BLEND_ONE = 64'd65536;
  localparam longint FS = 64'sd8388608;
  localparam longint unsigned C1 = 64'd26353589;
  localparam longint unsigned C3 = 64'd10837479;
  localparam longint unsigned C5 = 64'd1337020;
  localparam longint unsigned C7 = 64'd78547;

  typedef struct {
    logic signed [23:0] mix_out;
    logic               voice_on;
  } mix_sample_t;

  mix_sample_t expected_samples[$];

  // register copy
  logic [31:0] r_base;
  logic [23:0] r_pdec, r_adec;
  logic [14:0] r_drive;
  logic [15:0] r_norm, r_vol, r_step;

  // voice state
  bit              sounding, blending;
  logic [31:0]     phase_acc, start_inc;
  longint unsigned pitch_lvl, amp_lvl, blend_pos;
  logic [15:0]     level;
  longint          blend_from, prev_voice;

  function automatic longint unsigned ratio_q16(input int r);
    longint unsigned t[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                               92682, 98193, 104032, 110218, 116772, 123715};
    return t[r];
  endfunction

  function automatic longint unsigned sine_q24(input logic [31:0] ph, output bit neg);
    longint unsigned idx, quad, w, x, x2, s, y;
    idx = ph >> 22;
    quad = (idx >> 8) & 3;
    w = idx & 255;
    if (quad[0]) w = 256 - w;
    neg = quad >= 2;
    x = w << 16;
    x2 = (x * x) >> 24;
    s = C5 - ((C7 * x2) >> 24);
    s = C3 - ((s * x2) >> 24);
    s = C1 - ((s * x2) >> 24);
    y = (s * x) >> 24;
    return (y > Q24_ONE) ? Q24_ONE : y;
  endfunction

  function automatic longint unsigned tanh_q24(input longint unsigned m);
    longint unsigned idx, x, x2, x4, x6, num, den, t;
    idx = m >> 15;
    if (idx >= 1024) return Q24_ONE;
    x = idx << 16;
    x2 = (x * x) >> 24;
    x4 = (x2 * x2) >> 24;
    x6 = (x4 * x2) >> 24;
    num = 135135 * Q24_ONE + 17325 * x2 + 378 * x4 + x6;
    den = 135135 * Q24_ONE + 62370 * x2 + 3150 * x4 + 28 * x6;
    t = (x * (num >> 12)) / (den >> 12);
    return (t > Q24_ONE) ? Q24_ONE : t;
  endfunction

  task automatic start_hit(input logic signed [6:0] semi, input logic [15:0] gain);
    int n, oct, rem;
    longint unsigned prod;
    n = int'(semi);
    oct = (n + 72) / 12 - 6;
    rem = (n + 72) % 12;
    prod = longint'(r_base) * ratio_q16(rem);
    if (oct >= 0) prod = prod << oct;
    else prod = prod >> (-oct);
    prod = prod >> 16;
    start_inc = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    blending = sounding;
    if (sounding) blend_from = prev_voice;
    blend_pos = 0;
    sounding = 1;
    phase_acc = '0;
    pitch_lvl = Q24_ONE;
    amp_lvl = Q24_ONE;
    level = gain;
  endtask

  task automatic voice_tick(input logic signed [23:0] mix_in, output mix_sample_t res);
    longint mix, v, r, u;
    longint unsigned inc, y, mag, um, t, m, old_amp;
    bit neg;
    mix = longint'(mix_in);
    if (!sounding) begin
      res.mix_out = mix_in;
      res.voice_on = 0;
      return;
    end
    inc = (longint'(start_inc) * (Q24_ONE + pitch_lvl)) >> 25;
    phase_acc = phase_acc + inc[31:0];
    y = sine_q24(phase_acc, neg);
    mag = (y * FS) >> 24;
    if (mag > FS - 1) mag = FS - 1;
    v = neg ? -longint'(mag) : longint'(mag);
    v = (v * longint'(amp_lvl)) / longint'(Q24_ONE);
    v = (v * longint'(level)) / 32768;
    if (r_drive != 0) begin
      u = (v * longint'(r_drive)) / 4096;
      um = (u < 0) ? -u : u;
      t = tanh_q24(um);
      m = (t * r_norm) >> 14;
      m = (m * FS) >> 24;
      v = (u < 0) ? -longint'(m) : longint'(m);
    end
    if (v < -FS) v = -FS;
    if (v > FS - 1) v = FS - 1;
    if (blending) begin
      if (blend_pos < BLEND_ONE) begin
        v = (blend_from * longint'(BLEND_ONE - blend_pos) + v * longint'(blend_pos))
            / longint'(BLEND_ONE);
        blend_pos = blend_pos + r_step;
        if (blend_pos > BLEND_ONE) blend_pos = BLEND_ONE;
      end else begin
        blending = 0;
      end
    end
    prev_voice = v;
    r = (v * longint'(r_vol) * 256) / FS;
    mix = mix + r;
    if (mix < -FS) mix = -FS;
    if (mix > FS - 1) mix = FS - 1;
    old_amp = amp_lvl;
    pitch_lvl = (pitch_lvl * r_pdec) >> 24;
    amp_lvl = (amp_lvl * r_adec) >> 24;
    if (old_amp < LEVEL_FLOOR) sounding = 0;
    res.mix_out = mix[23:0];
    res.voice_on = sounding;
  endtask

  always @(posedge clk) begin
    mix_sample_t got, want;
    if (!rst_n) begin
      r_base = 32'd5368709;
      r_pdec = 24'd16768477;
      r_adec = 24'd16775627;
      r_drive = 15'd9011;
      r_norm = 16'd16791;
      r_vol = 16'd32768;
      r_step = 16'd273;
      sounding = 0; blending = 0;
      phase_acc = '0; start_inc = '0; pitch_lvl = 0; amp_lvl = 0;
      blend_pos = 0; blend_from = 0; prev_voice = 0; level = '0;
      expected_samples.delete();
      fail_count <= 0;
      sample_count <= 0;
      hit_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BASE_INC:  r_base = cfg_data;
          CFG_PITCH_DEC: r_pdec = cfg_data[23:0];
          CFG_AMP_DEC:   r_adec = cfg_data[23:0];
          CFG_DRIVE:     r_drive = cfg_data[14:0];
          CFG_NORM:      r_norm = cfg_data[15:0];
          CFG_VOLUME:    r_vol = cfg_data[15:0];
          CFG_DECLICK:   r_step = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (!in_mon.kind) begin
          start_hit(in_mon.semitone_offset, in_mon.level_gain);
          hit_count <= hit_count + 1;
        end else begin
          voice_tick(in_mon.mix_in, want);
          expected_samples.push_back(want);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.mix_out = out_mon.mix_out;
        got.voice_on = out_mon.voice_on;
        sample_count <= sample_count + 1;
        if (expected_samples.size() == 0) begin
          if (fail_count < 10) $display("unexpected result mix_out=%0d voice_on=%0b",
                                        got.mix_out, got.voice_on);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (got.mix_out !== want.mix_out || got.voice_on !== want.voice_on) begin
            if (fail_count < 10)
              $display("mismatch at %0t: mix_out %0d (exp %0d) voice_on %0b (exp %0b)",
                       $realtime, got.mix_out, want.mix_out, got.voice_on, want.voice_on);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_samples.size();
  end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// top of the kick drum voice testbench: clock, reset, stimulus and verdict
// depends on kdv_pkg, kdv_if, kdv_voice_checker and the unit itself
`default_nettype none
module testbench import kdv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending, sample_count, hit_count;
  int          max_gap = 19;   // idle range for both sides, 0 gives back-to-back
  int          hold_req = 0;   // long receiver hold-off, taken up by the receiver
  int          phase_count = 0;

  kdv_in_if  in_chan();
  kdv_out_if out_chan();

  kick_drum_voice_synth_unit uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kdv_voice_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .sample_count(sample_count), .hit_count(hit_count)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // known values on every input from time zero
  initial begin
    in_chan.valid = 0;
    in_chan.kind = 1;
    in_chan.semitone_offset = '0;
    in_chan.level_gain = '0;
    in_chan.mix_in = '0;
    out_chan.ready = 0;
  end

  // safety net: worst case stays under 2 ms of simulated time
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stall per result, and one long hold-off when the stimulus asks for it
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req > 0) begin
        w = hold_req;
        hold_req = 0;
        out_chan.ready <= 0;
        repeat (w) @(posedge clk);
      end else begin
        w = $urandom_range(0, max_gap);
        if (w > 0) begin
          out_chan.ready <= 0;
          repeat (w) @(posedge clk);
        end
      end
      out_chan.ready <= 1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // one input transaction; valid only drops when a gap is drawn
  task automatic send(input logic kind, input logic signed [6:0] semi,
                      input logic [15:0] gain, input logic signed [23:0] mix);
    int g;
    g = $urandom_range(0, max_gap);
    if (g > 0) begin
      in_chan.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_chan.kind <= kind;
    in_chan.semitone_offset <= semi;
    in_chan.level_gain <= gain;
    in_chan.mix_in <= mix;
    in_chan.valid <= 1;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic trigger(input logic signed [6:0] semi, input logic [15:0] gain);
    send(1'b0, semi, gain, 24'($urandom));
  endtask

  task automatic tick(input logic signed [23:0] mix);
    send(1'b1, 7'($urandom), 16'($urandom), mix);
  endtask

  // stop offering, then let every result drain and the unit fall idle
  task automatic settle();
    in_chan.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // full register set, written back to back while idle
  task automatic load_regs(input logic [31:0] base, input logic [23:0] pdec,
                           input logic [23:0] adec, input logic [14:0] drv,
                           input logic [15:0] norm, input logic [15:0] vol,
                           input logic [15:0] step);
    logic [31:0] vals[7];
    vals = '{base, 32'(pdec), 32'(adec), 32'(drv), 32'(norm), 32'(vol), 32'(step)};
    foreach (vals[i]) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic signed [23:0] rand_mix();
    case ($urandom_range(0, 9))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return '0;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int n_items;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: silent ticks, plain hit, retrigger while sounding, offset extremes
    tick(24'sh7FFFFF);
    tick(24'sh800000);
    tick(24'sh000000);
    trigger(7'sd0, 16'd32768);
    repeat (3) tick(24'sh000000);
    trigger(7'sd48, 16'hFFFF);          // retrigger starts the crossfade
    tick(24'sh7FFFFF);
    tick(24'sh800000);
    trigger(-7'sd48, 16'd0);            // zero level
    tick(24'sh123456);
    trigger(-7'sd64, 16'd1);            // offset beyond the nominal range
    tick(24'sh000000);
    trigger(7'sd63, 16'h7FFF);
    repeat (4) tick(rand_mix());
    settle();

    // phases over distinct register settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_regs(32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 15'h7FFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: load_regs(32'h0, 24'h0, 24'h0, 15'h0, 16'h0, 16'h0, 16'h0);
        2: load_regs(32'd5368709, 24'd16000000, 24'd15500000, 15'd0,
                     16'd16791, 16'd32768, 16'd0);    // bypassed drive, held blend
        3: load_regs(32'($urandom), 24'($urandom_range(15000000, 16777215)),
                     24'($urandom_range(15000000, 16700000)), 15'($urandom_range(1, 4095)),
                     16'($urandom), 16'($urandom), 16'($urandom_range(1, 4000)));
        default: load_regs(32'($urandom_range(0, 60000000)),
                           24'($urandom_range(14000000, 16777215)),
                           24'($urandom_range(14500000, 16700000)),
                           ($urandom_range(0, 3) == 0) ? 15'd0 : 15'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
      endcase
      max_gap = (ph % 3 == 2) ? 0 : 19;
      phase_count++;
      n_items = 0;
      while (n_items < 165) begin
        if (ph == 3 && n_items == 20) hold_req = 400;   // fill the unit and back up input
        if ($urandom_range(0, 99) < 8)
          trigger(7'($urandom), ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
        else
          tick(rand_mix());
        n_items++;
      end
      settle();
    end
    max_gap = 19;

    $display("covered %0d phases of register settings with %0d hits", phase_count, hit_count);
    $display("%0d mix samples checked, %0d mismatches", sample_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: kick_drum_voice_synth_unit.f
+incdir+src
src/kdv_pkg.sv
src/kdv_if.sv
src/kdv_cfg_regs.sv
src/kdv_ctrl.sv
src/kdv_datapath.sv
src/kick_drum_voice_synth_unit.sv
src/kdv_checker.sv
tb/sv/kdv_voice_checker.sv
tb/sv/testbench.sv
